[hdl/assert_macros.svh]
// Assertion macros used by the checker module of the sorted key store.
// Depends on nothing; expects signals clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define SLIS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define SLIS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/slis_pkg.sv]
// Package for the sorted key store: key type, operation codes and the
// flag bundle that each cell hands to its right neighbor. No dependencies.
package slis_pkg;

  localparam int KEY_W = 32;
  localparam int POS_W = 4;
  localparam int CNT_OUT_W = 5;

  typedef logic signed [KEY_W-1:0] key_t;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Compare flags of one cell, captured in the compare cycle
  typedef struct packed {
    logic vld;  // cell holds a key
    logic gt;   // held key is strictly greater than the item key
    logic eq;   // held key equals the item key
  } cell_flags_t;

endpackage

[hdl/slis_cell.sv]
// One cell of the sorted key chain: holds a key, compares it with the
// broadcast item key and shifts toward higher positions on insert. Uses slis_pkg.
module slis_cell import slis_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmp_en,     // capture compare flags
  input  logic        ins_en,     // apply a non-dropped insert
  input  key_t        item_key,
  input  key_t        prev_key,
  input  cell_flags_t prev_flags,
  output key_t        key_o,
  output cell_flags_t flags_o,
  output logic        take_o,     // insert key lands in this cell
  output logic        first_eq_o  // lowest matching cell
);

  key_t        key_r;
  logic        vld_r;
  logic        gt_r;
  logic        eq_r;
  logic        shift;

  // Insert point: first greater cell, or the first empty one
  assign take_o     = (vld_r ? gt_r : prev_flags.vld) && !prev_flags.gt;
  assign shift      = prev_flags.gt;
  assign first_eq_o = eq_r && !prev_flags.eq;

  assign key_o   = key_r;
  assign flags_o = '{vld: vld_r, gt: gt_r, eq: eq_r};

  // Compare flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (cmp_en) begin
      gt_r <= vld_r && (item_key < key_r);
      eq_r <= vld_r && (item_key == key_r);
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ins_en && (take_o || shift)) begin
      vld_r <= 1'b1;
    end
  end

  // Held key, no reset
  always_ff @(posedge clk) begin
    if (ins_en) begin
      if (shift) begin
        key_r <= prev_key;
      end else if (take_o) begin
        key_r <= item_key;
      end
    end
  end

endmodule

[hdl/slis_enc.sv]
// One-hot to binary encoder over the cell row; yields the cell index.
// No package dependency.
module slis_enc #(
  parameter int N  = 16,
  parameter int IW = 4
) (
  input  logic [N-1:0]  vec,
  output logic [IW-1:0] idx
);

  // OR together the indexes of the set bits (at most one is set)
  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (vec[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule

[hdl/sorted_list_insert_search.sv]
// Sorted key store built from a chain of compare/shift cells.
// An accepted item passes through a compare state and an update state before the
// result is registered; no new item is taken until the sequencer is back to idle,
// and a waiting result stalls the update state.
// Reset: synchronous active-low; clears the entry count and all cell valid bits.
module sorted_list_insert_search import slis_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic signed [31:0]   in_key,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_found,
  output logic [POS_W-1:0]     out_position,
  output logic                 out_overflow,
  output logic [CNT_OUT_W-1:0] out_entry_count
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic                 op_r;
  key_t                 key_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 out_valid_r;
  logic                 found_r;
  logic [POS_W-1:0]     pos_r;
  logic                 ovf_r;

  key_t                 cell_key   [CAPACITY];
  cell_flags_t          cell_flags [CAPACITY];
  logic [CAPACITY-1:0]  take_vec;
  logic [CAPACITY-1:0]  first_vec;
  logic [CAPACITY-1:0]  enc_vec;
  logic [IW-1:0]        enc_idx;

  logic                 full;
  logic                 is_ins;
  logic                 upd_go;
  logic                 ins_en;
  logic                 res_found;

  assign full    = (count_r == CW'(CAPACITY));
  assign is_ins  = (op_r == OP_INSERT);
  assign upd_go  = (state_r == ST_UPD) && (!out_valid_r || out_ready);
  assign ins_en  = upd_go && is_ins && !full;
  assign in_ready = (state_r == ST_IDLE);

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t        prev_key;
    cell_flags_t prev_flags;
    if (i == 0) begin : g_head
      assign prev_key   = key_r;
      assign prev_flags = '{vld: 1'b1, gt: 1'b0, eq: 1'b0};
    end else begin : g_body
      assign prev_key   = cell_key[i-1];
      assign prev_flags = cell_flags[i-1];
    end
    slis_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmp_en     (state_r == ST_CMP),
      .ins_en     (ins_en),
      .item_key   (key_r),
      .prev_key   (prev_key),
      .prev_flags (prev_flags),
      .key_o      (cell_key[i]),
      .flags_o    (cell_flags[i]),
      .take_o     (take_vec[i]),
      .first_eq_o (first_vec[i])
    );
  end

  // Position encode
  assign enc_vec = is_ins ? take_vec : first_vec;

  slis_enc #(.N(CAPACITY), .IW(IW)) u_enc (
    .vec (enc_vec),
    .idx (enc_idx)
  );

  assign res_found = is_ins ? !full : |first_vec;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  if (upd_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Captured item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_op;
      key_r <= in_key;
    end
  end

  // Entry count
  assign count_nxt = ins_en ? count_r + CW'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      found_r <= res_found;
      pos_r   <= res_found ? POS_W'(enc_idx) : '0;
      ovf_r   <= is_ins && full;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_position    = pos_r;
  assign out_overflow    = ovf_r;
  assign out_entry_count = CNT_OUT_W'(count_r);

endmodule

[hdl/slis_chk.sv]
// Port-level checker for the sorted key store, bound to the top level.
// Depends on slis_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slis_chk import slis_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_found,
  input logic [POS_W-1:0]     out_position,
  input logic                 out_overflow,
  input logic [CNT_OUT_W-1:0] out_entry_count
);

  // A stalled result transaction holds its payload
  `SLIS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_position) && $stable(out_found), "result changed while stalled")

  // A dropped insert reports no position and no hit
  `SLIS_ASSERT(a_ovf_clean, out_valid && out_overflow |-> !out_found && out_position == '0, "overflow result carries a hit")

  // Overflow only with a full store
  `SLIS_ASSERT(a_ovf_full, out_valid && out_overflow |-> out_entry_count == CNT_OUT_W'(CAPACITY), "overflow without full store")

  // No result right after reset
  `SLIS_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid, "result valid after reset")

  // An accepted input is not taken again in the next cycle
  `SLIS_ASSERT(a_seq_accept, in_valid && in_ready |=> !in_ready, "back-to-back accept")

endmodule

bind sorted_list_insert_search slis_chk #(.CAPACITY(CAPACITY)) u_slis_chk (.*);

[tb/sorted_list_insert_search_test.sv]
// Self-checking testbench for sorted_list_insert_search: a directed table, then random
// transactions, each result checked against its table row or a local model of the store.
// Depends on slis_pkg and the sorted_list_insert_search RTL.
module sorted_list_insert_search_test;
  import slis_pkg::*;

  localparam int STORE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1325;

  // One result transaction, field by field
  typedef struct packed {
    logic                 found;
    logic [POS_W-1:0]     position;
    logic                 overflow;
    logic [CNT_OUT_W-1:0] entry_count;
  } store_result_t;

  // One row of the directed table; exp is used only when typed is set
  typedef struct packed {
    logic          op;
    key_t          key;
    logic          typed;
    store_result_t exp;
  } stim_row_t;

  // Receiver behavior, switched at random
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_CHOKED
  } sink_mode_t;

  localparam store_result_t UNTYPED = '0;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_op;
  key_t                 in_key;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_found;
  logic [POS_W-1:0]     out_position;
  logic                 out_overflow;
  logic [CNT_OUT_W-1:0] out_entry_count;

  // Local copy of the store
  key_t store_keys [STORE_DEPTH];
  int   store_count;

  store_result_t expected_q [$];
  store_result_t want;
  store_result_t predicted;

  // Typed expectation travelling with the transaction on the input port
  logic          cur_typed;
  store_result_t cur_exp;

  int errors;
  int inserts_seen;
  int searches_seen;
  int drops_seen;
  int hits_seen;
  int burst_left;

  // Directed table: empty store, extremes, equal keys, fill to full, drops on full
  stim_row_t directed_rows [0:25] = '{
    '{OP_SEARCH, 32'h0000_0000, 1'b1, '{1'b0, 4'd0,  1'b0, 5'd0}},
    '{OP_SEARCH, 32'h8000_0000, 1'b1, '{1'b0, 4'd0,  1'b0, 5'd0}},
    '{OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b1, 4'd0,  1'b0, 5'd1}},
    '{OP_INSERT, 32'h8000_0000, 1'b1, '{1'b1, 4'd0,  1'b0, 5'd2}},
    '{OP_INSERT, 32'h0000_0000, 1'b1, '{1'b1, 4'd1,  1'b0, 5'd3}},
    '{OP_INSERT, 32'h0000_0000, 1'b0, UNTYPED},
    '{OP_SEARCH, 32'h0000_0000, 1'b0, UNTYPED},
    '{OP_SEARCH, 32'h7FFF_FFFF, 1'b0, UNTYPED},
    '{OP_SEARCH, 32'h8000_0000, 1'b1, '{1'b1, 4'd0,  1'b0, 5'd4}},
    '{OP_SEARCH, 32'h0000_0001, 1'b0, UNTYPED},
    '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, UNTYPED},
    '{OP_INSERT, 32'h0001_0000, 1'b0, UNTYPED},
    '{OP_INSERT, 32'hFFFF_0000, 1'b0, UNTYPED},
    '{OP_INSERT, 32'h5555_5555, 1'b0, UNTYPED},
    '{OP_INSERT, 32'hAAAA_AAAA, 1'b0, UNTYPED},
    '{OP_INSERT, 32'h8000_0000, 1'b0, UNTYPED},
    '{OP_INSERT, 32'h7FFF_FFFF, 1'b0, UNTYPED},
    '{OP_INSERT, 32'h0000_8000, 1'b0, UNTYPED},
    '{OP_INSERT, 32'h1234_5678, 1'b0, UNTYPED},
    '{OP_INSERT, 32'hEDCB_A988, 1'b0, UNTYPED},
    '{OP_INSERT, 32'h7FFF_FFFE, 1'b0, UNTYPED},
    '{OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b1, 4'd15, 1'b0, 5'd16}},
    '{OP_INSERT, 32'h0000_0000, 1'b1, '{1'b0, 4'd0,  1'b1, 5'd16}},
    '{OP_INSERT, 32'h8000_0000, 1'b1, '{1'b0, 4'd0,  1'b1, 5'd16}},
    '{OP_SEARCH, 32'h7FFF_FFFF, 1'b0, UNTYPED},
    '{OP_SEARCH, 32'h5555_5555, 1'b0, UNTYPED}
  };

  sorted_list_insert_search #(
    .CAPACITY(STORE_DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_position    (out_position),
    .out_overflow    (out_overflow),
    .out_entry_count (out_entry_count)
  );

  // Ordered insert / lowest-match search on the local store
  function automatic store_result_t apply_to_store(input logic op, input key_t key);
    store_result_t r;
    int            slot;
    int            i;
    logic          hit;
    r = '0;
    hit = 1'b0;
    if (op == OP_INSERT) begin
      if (store_count >= STORE_DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        // first key strictly greater wins; equal keys stay in arrival order
        slot = store_count;
        for (i = 0; i < store_count; i++) begin
          if (!hit && key < store_keys[i]) begin
            slot = i;
            hit = 1'b1;
          end
        end
        for (i = store_count; i > slot; i--) store_keys[i] = store_keys[i-1];
        store_keys[slot] = key;
        store_count++;
        r.found = 1'b1;
        r.position = POS_W'(slot);
      end
    end else begin
      for (i = 0; i < store_count; i++) begin
        if (!hit && store_keys[i] == key) begin
          hit = 1'b1;
          r.found = 1'b1;
          r.position = POS_W'(i);
        end
      end
    end
    r.entry_count = CNT_OUT_W'(store_count);
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #1200000;
    $error("timeout with %0d results still outstanding", expected_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  // Result checking and prediction at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      // check the output transaction first, so a new expectation never hides a stray result
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: found=%0d position=%0d overflow=%0d count=%0d",
                 out_found, out_position, out_overflow, out_entry_count);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_found);
            errors++;
          end
          if (out_position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, out_position);
            errors++;
          end
          if (out_overflow !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, out_overflow);
            errors++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, out_entry_count);
            errors++;
          end
          if (want.overflow) drops_seen++;
        end
      end
      if (in_valid && in_ready) begin
        predicted = apply_to_store(in_op, in_key);
        expected_q.push_back(cur_typed ? cur_exp : predicted);
        if (in_op == OP_INSERT) inserts_seen++;
        else begin
          searches_seen++;
          if (predicted.found) hits_seen++;
        end
      end
    end
  end

  // Receiver: ready pattern of its own, changed at the falling edge
  initial begin : result_sink
    sink_mode_t mode;
    int         mode_left;
    mode = SINK_OPEN;
    mode_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      case (mode)
        SINK_OPEN: begin
          out_ready <= 1'b1;
        end
        SINK_RANDOM: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_ready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  // Entered at a falling edge; returns at the falling edge after acceptance
  task automatic drive_item(input logic op, input key_t key, input logic typed,
                            input store_result_t exp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= op;
    in_key <= key;
    cur_typed = typed;
    cur_exp = exp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender holds off until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // Stimulus
  initial begin : stimulus
    int   n;
    int   roll;
    logic op;
    key_t key;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_INSERT;
    in_key = '0;
    cur_typed = 1'b0;
    cur_exp = '0;
    store_count = 0;
    errors = 0;
    inserts_seen = 0;
    searches_seen = 0;
    drops_seen = 0;
    hits_seen = 0;
    burst_left = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (n = 0; n < $size(directed_rows); n++) begin
      drive_item(directed_rows[n].op, directed_rows[n].key, directed_rows[n].typed,
                 directed_rows[n].exp);
    end
    drain_results();

    // Random part: the store is full by now, so most searches target stored keys
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400 || n == 900) drain_results();
      roll = $urandom_range(0, 99);
      op = OP_SEARCH;
      key = key_t'($urandom);
      if (roll < 55 && store_count > 0) begin
        key = store_keys[$urandom_range(0, store_count - 1)];
      end else if (roll < 70 && store_count > 0) begin
        // near miss next to a stored key
        key = store_keys[$urandom_range(0, store_count - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      end else if (roll >= 85) begin
        op = OP_INSERT;
      end
      drive_item(op, key, 1'b0, UNTYPED);
    end

    // Wait out the last results, then keep watching for anything stray
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d inserts (%0d dropped on a full store) and %0d searches (%0d hits),",
             inserts_seen, drops_seen, searches_seen, hits_seen);
    $display("with bursty input, a stalling receiver and %0d mismatches.", errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sorted_list_insert_search.f]
+incdir+hdl
hdl/slis_pkg.sv
hdl/slis_cell.sv
hdl/slis_enc.sv
hdl/sorted_list_insert_search.sv
hdl/slis_chk.sv
tb/sorted_list_insert_search_test.sv
